FILE: sv/qmr_pkg.sv
// Shared types and defaults for the quaternion multiply/rotate unit.
`default_nettype none

package qmr_pkg;

   // default component format: signed Q2.14
   localparam int COMP_WIDTH_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 14;

   // operation selected by the request's tuser bit
   typedef enum logic {
      ACT_PRODUCT = 1'b0,
      ACT_ROTATE  = 1'b1
   } qmr_action_type;

   // load enables for the three register stages of one Hamilton product unit
   typedef struct packed {
      logic mul;
      logic sum;
      logic fin;
   } qmr_stage_en_type;

endpackage

`default_nettype wire

FILE: sv/qmr_hamilton.sv
// Three-stage pipelined Hamilton product with round-to-nearest and saturation.
`default_nettype none

module qmr_hamilton #(
   parameter int W  = qmr_pkg::COMP_WIDTH_DEFAULT,
   parameter int F  = qmr_pkg::FRAC_BITS_DEFAULT,
   parameter int BW = qmr_pkg::COMP_WIDTH_DEFAULT
) (
   input  wire  logic                      clock,
   input  wire  qmr_pkg::qmr_stage_en_type en,
   input  wire  logic signed [W-1:0]       a [4],
   input  wire  logic signed [BW-1:0]      b [4],
   output logic signed [W-1:0]             r [4],
   output logic [3:0]                      sat
);
   import qmr_pkg::*;

   localparam int PW = W + BW;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

   // operand indexes per term, four terms per component in w,x,y,z order;
   // the last term of x,y,z and the last three of w are subtracted
   localparam logic [1:0] A_IDX [16] = '{
      2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd2, 2'd3, 2'd1,
      2'd0, 2'd3, 2'd1, 2'd2
   };
   localparam logic [1:0] B_IDX [16] = '{
      2'd0, 2'd1, 2'd2, 2'd3,
      2'd1, 2'd0, 2'd3, 2'd2,
      2'd2, 2'd0, 2'd1, 2'd3,
      2'd3, 2'd0, 2'd2, 2'd1
   };

   logic signed [PW-1:0] prod_ff [16];
   logic signed [PW-1:0] prod_in [16];
   logic signed [SW-1:0] term    [16];
   logic signed [SW-1:0] sum_ff  [4];
   logic signed [SW-1:0] sum_in  [4];
   logic signed [W-1:0]  res_ff  [4];
   logic signed [W-1:0]  res_in  [4];
   logic [3:0]           sat_ff;
   logic [3:0]           sat_in;

   // stage 1: sixteen signed products
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         prod_in[k] = PW'(a[A_IDX[k]]) * PW'(b[B_IDX[k]]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
      end
   end

   // stage 2: signed sums plus half an LSB for rounding
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         term[k] = SW'(prod_ff[k]);
      end
      sum_in[0] = term[0] - term[1] - term[2] - term[3] + HALF;
      for (int c = 1; c < 4; c++) begin
         sum_in[c] = term[4*c] + term[4*c+1] + term[4*c+2] - term[4*c+3] + HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         sum_ff <= sum_in;
      end
   end

   // stage 3: drop fraction bits, clip when the upper bits are not all sign
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if ((sum_ff[c][SW-1:F+W-1] == '0) || (sum_ff[c][SW-1:F+W-1] == '1)) begin
            res_in[c] = sum_ff[c][F+W-1:F];
            sat_in[c] = 1'b0;
         end else begin
            res_in[c] = sum_ff[c][SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            sat_in[c] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.fin) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign r   = res_ff;
   assign sat = sat_ff;

endmodule

`default_nettype wire

FILE: sv/quaternion_multiply_rotate_unit.sv
// Top level of the quaternion multiply/rotate unit: stream ports and pipeline control.
//
// Usage:
//   req_* carries one request per handshake: tdata holds q_w,q_x,q_y,q_z,p_w,
//   p_x,p_y,p_z (COMPONENT_WIDTH bits each, signed fixed point), tuser holds
//   the action (0 = Hamilton product q*p, 1 = rotate vector p by q).
//   rsp_* returns one result per request, in request order: tdata holds
//   r_w,r_x,r_y,r_z and tuser flags that some component was clipped.
//   The pipeline has six register stages; a request accepted on req_* moves
//   through them in turn and raises rsp_tvalid when it reaches the last. The
//   stages are two Hamilton product units back to back, each multiply, sum,
//   round/saturate. Product requests pass through the second unit's stages
//   and return the first unit's result, carried alongside.
//   Throughput is one request per cycle while the receiver does not stall.
//   Each stage carries a valid bit and loads whenever it is empty or its
//   successor loads, so bubbles close up while the receiver stalls and
//   req_tready drops only when all six stages hold requests.
//   Reset (synchronous, active high) empties the pipeline; no clearing pass.
`default_nettype none

module quaternion_multiply_rotate_unit #(
   parameter int COMPONENT_WIDTH = qmr_pkg::COMP_WIDTH_DEFAULT,
   parameter int FRACTION_BITS   = qmr_pkg::FRAC_BITS_DEFAULT
) (
   input  wire  logic                                        clock,
   input  wire  logic                                        reset,
   input  wire  logic                                        req_tvalid,
   output logic                                              req_tready,
   // q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z from bit 0 up
   input  wire  logic [8*COMPONENT_WIDTH-1:0]                req_tdata,
   // action
   input  wire  logic [0:0]                                  req_tuser,
   output logic                                              rsp_tvalid,
   input  wire  logic                                        rsp_tready,
   // r_w, r_x, r_y, r_z from bit 0 up, zero filled to whole bytes
   output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]            rsp_tdata,
   // saturated
   output logic [0:0]                                        rsp_tuser
);
   import qmr_pkg::*;

   localparam int W      = COMPONENT_WIDTH;
   localparam int NSTAGE = 6;

   logic [NSTAGE-1:0]    vld_ff;
   logic [NSTAGE-1:0]    vld_in;
   logic [NSTAGE:0]      rdy;
   qmr_action_type       act_ff [NSTAGE];
   qmr_action_type       req_act;

   logic signed [W-1:0]  req_q  [4];
   logic signed [W-1:0]  req_p  [4];
   logic signed [W-1:0]  q_ff   [3][4];
   logic signed [W-1:0]  r1_ff  [3][4];
   logic [2:0]           sat1_ff;

   logic signed [W-1:0]  h1_b   [4];
   logic signed [W-1:0]  h1_r   [4];
   logic [3:0]           h1_sat;
   logic signed [W:0]    qc     [4];
   logic signed [W-1:0]  h2_r   [4];
   logic [3:0]           h2_sat;
   logic signed [W-1:0]  rsp_r  [4];

   qmr_stage_en_type     h1_en;
   qmr_stage_en_type     h2_en;

   // unpack request fields
   assign req_act = qmr_action_type'(req_tuser[0]);
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         req_q[i] = $signed(req_tdata[i*W +: W]);
         req_p[i] = $signed(req_tdata[(i+4)*W +: W]);
      end
   end

   // stage load enables: a stage loads when empty or when its successor loads
   always_comb begin
      rdy[NSTAGE] = rsp_tready;
      for (int k = NSTAGE - 1; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
   end

   assign req_tready = rdy[0];

   always_comb begin
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         if (rdy[k]) begin
            vld_in[k] = vld_ff[k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // action travels with every stage
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         act_ff[0] <= req_act;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (rdy[k]) begin
            act_ff[k] <= act_ff[k-1];
         end
      end
   end

   // q follows the first unit so that its conjugate is at hand for the second
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         q_ff[0] <= req_q;
      end
      for (int k = 1; k < 3; k++) begin
         if (rdy[k]) begin
            q_ff[k] <= q_ff[k-1];
         end
      end
   end

   // first unit: q*p, or q*(0,p_v) when rotating
   always_comb begin
      h1_b    = req_p;
      h1_b[0] = (req_act == ACT_ROTATE) ? '0 : req_p[0];
   end

   assign h1_en = '{mul: rdy[0], sum: rdy[1], fin: rdy[2]};

   qmr_hamilton #(
      .W  (W),
      .F  (FRACTION_BITS),
      .BW (W)
   ) u_ham1 (
      .clock (clock),
      .en    (h1_en),
      .a     (req_q),
      .b     (h1_b),
      .r     (h1_r),
      .sat   (h1_sat)
   );

   // second unit: t*conj(q), conjugate exact at one extra bit
   always_comb begin
      qc[0] = (W+1)'(q_ff[2][0]);
      for (int i = 1; i < 4; i++) begin
         qc[i] = -((W+1)'(q_ff[2][i]));
      end
   end

   assign h2_en = '{mul: rdy[3], sum: rdy[4], fin: rdy[5]};

   qmr_hamilton #(
      .W  (W),
      .F  (FRACTION_BITS),
      .BW (W + 1)
   ) u_ham2 (
      .clock (clock),
      .en    (h2_en),
      .a     (h1_r),
      .b     (qc),
      .r     (h2_r),
      .sat   (h2_sat)
   );

   // first-unit result and clip flag ride alongside the second unit
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         r1_ff[0]   <= h1_r;
         sat1_ff[0] <= |h1_sat;
      end
      for (int k = 1; k < 3; k++) begin
         if (rdy[k+3]) begin
            r1_ff[k]   <= r1_ff[k-1];
            sat1_ff[k] <= sat1_ff[k-1];
         end
      end
   end

   // response select: rotate returns the vector part only, scalar zero
   always_comb begin
      if (act_ff[NSTAGE-1] == ACT_ROTATE) begin
         rsp_r[0] = '0;
         for (int i = 1; i < 4; i++) begin
            rsp_r[i] = h2_r[i];
         end
         rsp_tuser[0] = sat1_ff[2] | (|h2_sat[3:1]);
      end else begin
         rsp_r        = r1_ff[2];
         rsp_tuser[0] = sat1_ff[2];
      end
      rsp_tdata = '0;
      for (int i = 0; i < 4; i++) begin
         rsp_tdata[i*W +: W] = rsp_r[i];
      end
   end

   assign rsp_tvalid = vld_ff[NSTAGE-1];

`ifndef NO_ASSERTIONS
   // an accepted request always occupies the first stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted request missing from first stage");

   // backpressure reaches the request side only when every stage is full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff))
      else $error("request stalled with a bubble in the pipeline");

   // a rotate response never carries a scalar part
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && act_ff[NSTAGE-1] == ACT_ROTATE) |-> (rsp_tdata[W-1:0] == '0))
      else $error("rotate response with nonzero scalar");

   // the third stage keeps its request while it cannot move on
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !rdy[3]) |=> vld_ff[2])
      else $error("stalled request dropped from third stage");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking stream bench for the quaternion multiply/rotate unit.
module tb;
   import qmr_pkg::*;

   localparam int CW = COMP_WIDTH_DEFAULT;
   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int RSP_WIDTH = ((4 * CW + 7) / 8) * 8;
   localparam longint COMP_MAX = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COMP_MIN = -(longint'(1) <<< (CW - 1));
   localparam int NUM_DIRECTED = 21;
   localparam int RANDOM_REQUESTS = 500;
   localparam int IDLE_PERCENT = 37;
   localparam int HOLD_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;

   // component 0 is w, then x, y, z; w sits in the lowest bits
   typedef logic [3:0][CW-1:0] quat_t;

   typedef struct packed {
      qmr_action_type action;
      quat_t          q;
      quat_t          p;
   } request_t;

   typedef struct packed {
      quat_t r;
      logic  sat;
   } result_t;

   // known set: the result is typed into the row, else it comes from the predictor
   typedef struct packed {
      request_t req;
      logic     known;
      result_t  res;
   } row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [8*CW-1:0]       req_tdata = '0;   // q_w, q_x, q_y, q_z, p_w, p_x, p_y, p_z
   logic [0:0]            req_tuser = '0;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0]  rsp_tdata;        // r_w, r_x, r_y, r_z
   logic [0:0]            rsp_tuser;        // saturated

   result_t pending_results[$];
   int      accepted_requests = 0;
   int      mismatches = 0;
   int      idle_cycles = 0;
   string   field_name [4] = '{"r_w", "r_x", "r_y", "r_z"};

   quaternion_multiply_rotate_unit #(
      .COMPONENT_WIDTH(CW),
      .FRACTION_BITS(FB)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic quat_t quat(input int w, input int x, input int y, input int z);
      quat_t v;
      v[0] = w[CW-1:0];
      v[1] = x[CW-1:0];
      v[2] = y[CW-1:0];
      v[3] = z[CW-1:0];
      return v;
   endfunction

   function automatic row_t row(input qmr_action_type act, input quat_t q, input quat_t p,
                                input logic known, input quat_t r, input logic sat);
      row_t e;
      e.req.action = act;
      e.req.q = q;
      e.req.p = p;
      e.known = known;
      e.res.r = r;
      e.res.sat = sat;
      return e;
   endfunction

   function automatic longint widen(input logic [CW-1:0] v);
      return longint'($signed(v));
   endfunction

   // exact sums of the Hamilton product a*b, order w, x, y, z
   function automatic void hamilton_sums(input longint a [4], input longint b [4],
                                         output longint s [4]);
      s[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
      s[1] = a[0] * b[1] + b[0] * a[1] + a[2] * b[3] - a[3] * b[2];
      s[2] = a[0] * b[2] + b[0] * a[2] + a[3] * b[1] - a[1] * b[3];
      s[3] = a[0] * b[3] + b[0] * a[3] + a[1] * b[2] - a[2] * b[1];
   endfunction

   // add half an LSB, drop the fraction, clip to the component range
   function automatic logic [CW-1:0] round_clip(input longint acc, output logic clipped);
      longint v;
      v = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
      clipped = (v > COMP_MAX) || (v < COMP_MIN);
      if (v > COMP_MAX)
         v = COMP_MAX;
      else if (v < COMP_MIN)
         v = COMP_MIN;
      return v[CW-1:0];
   endfunction

   function automatic result_t compute_quaternion_result(input request_t rq);
      result_t res;
      longint  qa [4];
      longint  pa [4];
      longint  ta [4];
      longint  qc [4];
      longint  acc [4];
      logic    clipped;
      int      i;
      res.sat = 1'b0;
      for (i = 0; i < 4; i++) begin
         qa[i] = widen(rq.q[i]);
         pa[i] = widen(rq.p[i]);
      end
      if (rq.action == ACT_PRODUCT) begin
         hamilton_sums(qa, pa, acc);
         for (i = 0; i < 4; i++) begin
            res.r[i] = round_clip(acc[i], clipped);
            res.sat |= clipped;
         end
      end else begin
         // t = q*(0,v), held in component format; any clip of t counts
         pa[0] = 0;
         hamilton_sums(qa, pa, acc);
         for (i = 0; i < 4; i++) begin
            ta[i] = widen(round_clip(acc[i], clipped));
            res.sat |= clipped;
         end
         // conj(q) negated at full width, never clipped
         qc[0] = qa[0];
         for (i = 1; i < 4; i++)
            qc[i] = -qa[i];
         hamilton_sums(ta, qc, acc);
         // scalar is dropped, so its clip does not count
         res.r[0] = '0;
         for (i = 1; i < 4; i++) begin
            res.r[i] = round_clip(acc[i], clipped);
            res.sat |= clipped;
         end
      end
      return res;
   endfunction

   // bounded values stay near unit size, the rest lean on the extremes
   function automatic logic [CW-1:0] random_component(input bit bounded);
      if (bounded)
         return CW'($urandom_range(0, 23170)) - CW'(11585);
      case ($urandom_range(0, 9))
         0: return {1'b1, {(CW - 1){1'b0}}};
         1: return {1'b0, {(CW - 1){1'b1}}};
         2: return '0;
         3: return CW'(1 << FB);
         4: return -CW'(1 << FB);
         default: return CW'($urandom);
      endcase
   endfunction

   // window in which neither side idles
   function automatic bit quiet_window();
      return accepted_requests >= 250 && accepted_requests < 350;
   endfunction

   // offer one request, wait for the handshake, record what must come back
   task automatic send_request(input request_t rq, input logic known, input result_t typed_res);
      while (!quiet_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq.p, rq.q};
      req_tuser <= rq.action;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(known ? typed_res : compute_quaternion_result(rq));
      accepted_requests++;
      @(negedge clock);
   endtask

   // stimulus: directed table, then random requests, then drain
   initial begin
      row_t     directed_rows [NUM_DIRECTED];
      request_t rq;
      bit       bounded;
      int       n;
      int       i;
      directed_rows = '{
         row(ACT_PRODUCT, quat(0, 0, 0, 0), quat(0, 0, 0, 0),
             1'b1, quat(0, 0, 0, 0), 1'b0),
         row(ACT_PRODUCT, quat(16384, 0, 0, 0), quat(100, -200, 300, -400),
             1'b1, quat(100, -200, 300, -400), 1'b0),
         row(ACT_PRODUCT, quat(100, -200, 300, -400), quat(16384, 0, 0, 0),
             1'b1, quat(100, -200, 300, -400), 1'b0),
         // i * j = k
         row(ACT_PRODUCT, quat(0, 16384, 0, 0), quat(0, 0, 16384, 0),
             1'b1, quat(0, 0, 0, 16384), 1'b0),
         row(ACT_PRODUCT, quat(-32768, -32768, -32768, -32768),
             quat(-32768, -32768, -32768, -32768),
             1'b1, quat(-32768, 32767, 32767, 32767), 1'b1),
         row(ACT_PRODUCT, quat(32767, 32767, 32767, 32767), quat(32767, 32767, 32767, 32767),
             1'b1, quat(-32768, 32767, 32767, 32767), 1'b1),
         row(ACT_PRODUCT, quat(-32768, 0, 0, 0), quat(-32768, 0, 0, 0),
             1'b1, quat(32767, 0, 0, 0), 1'b1),
         row(ACT_PRODUCT, quat(0, -32768, 0, 0), quat(0, -32768, 0, 0),
             1'b1, quat(-32768, 0, 0, 0), 1'b1),
         // rounding ties go up
         row(ACT_PRODUCT, quat(1, 0, 0, 0), quat(8192, 0, 0, 0),
             1'b1, quat(1, 0, 0, 0), 1'b0),
         row(ACT_PRODUCT, quat(1, 0, 0, 0), quat(-8192, 0, 0, 0),
             1'b1, quat(0, 0, 0, 0), 1'b0),
         row(ACT_PRODUCT, quat(1, 0, 0, 0), quat(8191, 0, 0, 0),
             1'b1, quat(0, 0, 0, 0), 1'b0),
         row(ACT_PRODUCT, quat(1, 0, 0, 0), quat(-8193, 0, 0, 0),
             1'b1, quat(-1, 0, 0, 0), 1'b0),
         // identity rotation; p_w must be ignored and r_w forced to zero
         row(ACT_ROTATE, quat(16384, 0, 0, 0), quat(12345, 1000, -2000, 3000),
             1'b1, quat(0, 1000, -2000, 3000), 1'b0),
         row(ACT_ROTATE, quat(16384, 0, 0, 0), quat(-1, -32768, 32767, 0),
             1'b1, quat(0, -32768, 32767, 0), 1'b0),
         row(ACT_ROTATE, quat(0, 16384, 0, 0), quat(0, 1000, 2000, 3000),
             1'b0, '0, 1'b0),
         // conjugate of the most negative value
         row(ACT_ROTATE, quat(0, -32768, 0, 0), quat(0, 100, 200, 300),
             1'b0, '0, 1'b0),
         row(ACT_ROTATE, quat(23170, 23170, 0, 0), quat(0, 16384, 16384, 0),
             1'b0, '0, 1'b0),
         // intermediate clips
         row(ACT_ROTATE, quat(-32768, -32768, -32768, -32768),
             quat(-32768, -32768, -32768, -32768), 1'b0, '0, 1'b0),
         row(ACT_ROTATE, quat(32767, 32767, 32767, 32767), quat(32767, 32767, 32767, 32767),
             1'b0, '0, 1'b0),
         row(ACT_ROTATE, quat(16384, 16384, 16384, 16384), quat(0, 32767, -32768, 32767),
             1'b0, '0, 1'b0),
         row(ACT_PRODUCT, quat(12000, -7000, 3000, -25000), quat(-9000, 31000, -15000, 500),
             1'b0, '0, 1'b0)
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < NUM_DIRECTED; n++)
         send_request(directed_rows[n].req, directed_rows[n].known, directed_rows[n].res);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         bounded = $urandom_range(0, 99) < 40;
         rq.action = qmr_action_type'($urandom_range(0, 1));
         for (i = 0; i < 4; i++) begin
            rq.q[i] = random_component(bounded);
            rq.p[i] = random_component(bounded);
         end
         send_request(rq, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // receiver: random stalls, one long hold-off so the pipeline backs up
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && accepted_requests >= 60) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // response check against the oldest outstanding request
   always @(posedge clock) begin
      result_t want;
      int      i;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            for (i = 0; i < 4; i++) begin
               if (rsp_tdata[i*CW +: CW] !== want.r[i]) begin
                  $error("%s expected %0d actual %0d", field_name[i],
                         $signed(want.r[i]), $signed(rsp_tdata[i*CW +: CW]));
                  mismatches++;
               end
            end
            if (rsp_tuser[0] !== want.sat) begin
               $error("saturated expected %0b actual %0b", want.sat, rsp_tuser[0]);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

endmodule

FILE: files.f
sv/qmr_pkg.sv
sv/qmr_hamilton.sv
sv/quaternion_multiply_rotate_unit.sv
sim/tb.sv
